// File: sv/asa_pkg.sv
// Shared types, constants and helpers of the adaptive sample averager.
`timescale 1ns / 1ps
package asa_pkg;

  localparam int CHANNELS = 10;
  localparam int CH_W = $clog2(CHANNELS);
  localparam int DEF_MAX_SAMPLES = 32;
  localparam int COUNT_W = 6;
  localparam int LIM_W = COUNT_W + 1;
  localparam int MEAN_W = 24;
  localparam int INV_W = 20;
  localparam int FLOOR_W = 16;
  localparam int SAMPLE_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_SENSOR_ERROR = 2'd1;
  localparam logic [1:0] ST_NOT_CONVERGED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PRECISE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_TARGET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_FLOOR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM = 3'd5;

  typedef struct packed {
    logic        read_ok;
    logic [15:0] sample_0;
    logic [15:0] sample_1;
    logic [15:0] sample_2;
    logic [15:0] sample_3;
    logic [15:0] sample_4;
    logic [15:0] sample_5;
    logic [15:0] sample_6;
    logic [15:0] sample_7;
    logic [15:0] sample_8;
    logic [15:0] sample_9;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [23:0] mean_0;
    logic [23:0] mean_1;
    logic [23:0] mean_2;
    logic [23:0] mean_3;
    logic [23:0] mean_4;
    logic [23:0] mean_5;
    logic [23:0] mean_6;
    logic [23:0] mean_7;
    logic [23:0] mean_8;
    logic [23:0] mean_9;
  } out_item_t;

  typedef struct packed {
    logic               precise_mode;
    logic [5:0]         min_samples;
    logic [5:0]         max_attempts;
    logic [INV_W-1:0]   inv_target_squared;
    logic [FLOOR_W-1:0] noise_floor;
    logic [1:0]         confirm_hits;
  } cfg_t;

  typedef logic [CHANNELS-1:0][MEAN_W-1:0] mean_vec_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC,
    S_DECIDE,
    S_CHK_A,
    S_CHK_B,
    S_CHK_C,
    S_CHK_D,
    S_CHK_END,
    S_DIV_INIT,
    S_DIV_STEP,
    S_DIV_STORE,
    S_LOAD
  } state_t;

  typedef struct packed {
    logic            load;
    logic            acc;
    logic            chk_start;
    logic            chk_a;
    logic            chk_b;
    logic            chk_c;
    logic            chk_d;
    logic            hit_inc;
    logic            hit_clr;
    logic            div_init;
    logic            div_step;
    logic            div_store;
    logic            clear;
    logic            result_load;
    logic [CH_W-1:0] ch;
    logic [1:0]      status;
  } dp_cmd_t;

  typedef struct packed {
    logic               good;
    logic [COUNT_W-1:0] valid_count;
    logic [COUNT_W-1:0] attempt_count;
    logic [1:0]         hit_streak;
    logic               any_tested;
    logic               all_pass;
  } dp_stat_t;

  function automatic logic [SAMPLE_W-1:0] sample_at(in_item_t d, logic [CH_W-1:0] i);
    logic [SAMPLE_W-1:0] v;
    case (i)
      4'd0: v = d.sample_0;
      4'd1: v = d.sample_1;
      4'd2: v = d.sample_2;
      4'd3: v = d.sample_3;
      4'd4: v = d.sample_4;
      4'd5: v = d.sample_5;
      4'd6: v = d.sample_6;
      4'd7: v = d.sample_7;
      4'd8: v = d.sample_8;
      4'd9: v = d.sample_9;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic out_item_t build_result(logic [1:0] status, mean_vec_t m);
    out_item_t r;
    mean_vec_t z;
    z = (status == ST_OK) ? m : '0;
    r.status = status;
    r.mean_0 = z[0];
    r.mean_1 = z[1];
    r.mean_2 = z[2];
    r.mean_3 = z[3];
    r.mean_4 = z[4];
    r.mean_5 = z[5];
    r.mean_6 = z[6];
    r.mean_7 = z[7];
    r.mean_8 = z[8];
    r.mean_9 = z[9];
    return r;
  endfunction

endpackage

// File: sv/asa_datapath.sv
// Running sums, convergence arithmetic and mean divider of the averager.
`timescale 1ns / 1ps
module asa_datapath #(
  parameter int MAX_SAMPLES = asa_pkg::DEF_MAX_SAMPLES
) (
  input  logic               clk,
  input  logic               rst,
  input  asa_pkg::cfg_t      cfg,
  input  asa_pkg::in_item_t  item,
  input  asa_pkg::dp_cmd_t   cmd,
  output asa_pkg::dp_stat_t  stat,
  output asa_pkg::mean_vec_t means
);
  import asa_pkg::*;

  localparam int SUM_W = SAMPLE_W + $clog2(MAX_SAMPLES);
  localparam int SQ_W = 2 * SAMPLE_W + $clog2(MAX_SAMPLES);
  localparam int S2_W = 2 * SUM_W;
  localparam int NQ_W = COUNT_W + SQ_W;
  localparam int LHS_W = NQ_W + INV_W;
  localparam int RHS_W = COUNT_W + S2_W;
  localparam int CMP_W = (LHS_W > RHS_W) ? LHS_W : RHS_W;
  localparam int NUM_W = SUM_W + 8;
  localparam int REM_W = COUNT_W + 1;
  localparam int V2_W = 2 * SAMPLE_W;
  localparam int FN_W = FLOOR_W + COUNT_W;

  logic [SUM_W-1:0]   sum [CHANNELS];
  logic [SQ_W-1:0]    sq  [CHANNELS];
  logic [COUNT_W-1:0] valid_count;
  logic [COUNT_W-1:0] attempt_count;
  logic [1:0]         hit_streak;
  logic               good;
  in_item_t           item_r;

  logic [S2_W-1:0]    s2_r;
  logic [NQ_W-1:0]    nq_r;
  logic               tested_r;
  logic [NQ_W-1:0]    spread_r;
  logic [RHS_W-1:0]   rhs_r;
  logic [LHS_W-1:0]   lhs_r;
  logic               any_tested;
  logic               all_pass;

  logic [NUM_W-1:0]   dq;
  logic [REM_W-1:0]   rem;

  logic [SAMPLE_W-1:0]         v;
  logic [V2_W-1:0]             v2;
  logic [SUM_W-1:0]            s_cur;
  logic [SQ_W-1:0]             q_cur;
  logic [FN_W-1:0]             floor_n;
  logic [REM_W-1:0]            r2;
  logic [REM_W-1:0]            n_ext;

  assign v = sample_at(item_r, cmd.ch);
  assign v2 = V2_W'(v) * V2_W'(v);
  assign s_cur = sum[cmd.ch];
  assign q_cur = sq[cmd.ch];
  assign floor_n = FN_W'(cfg.noise_floor) * FN_W'(valid_count);
  assign r2 = {rem[REM_W-2:0], dq[NUM_W-1]};
  assign n_ext = REM_W'(valid_count);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int i = 0; i < CHANNELS; i++) begin
        sum[i] <= '0;
        sq[i] <= '0;
      end
      valid_count <= '0;
      attempt_count <= '0;
      hit_streak <= '0;
      good <= 1'b0;
    end else begin
      if (cmd.load) begin
        attempt_count <= attempt_count + 1'b1;
        if (item.read_ok && valid_count < COUNT_W'(MAX_SAMPLES)) begin
          good <= 1'b1;
          valid_count <= valid_count + 1'b1;
        end else begin
          good <= 1'b0;
        end
      end
      if (cmd.acc && good) begin
        sum[cmd.ch] <= s_cur + SUM_W'(v);
        sq[cmd.ch] <= q_cur + SQ_W'(v2);
      end
      if (cmd.hit_inc) begin
        hit_streak <= hit_streak + 2'd1;
      end else if (cmd.hit_clr) begin
        hit_streak <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= item;
    end
    if (cmd.chk_start) begin
      any_tested <= 1'b0;
      all_pass <= 1'b1;
    end
    if (cmd.chk_a) begin
      s2_r <= S2_W'(s_cur) * S2_W'(s_cur);
      nq_r <= NQ_W'(valid_count) * NQ_W'(q_cur);
      tested_r <= FN_W'(s_cur) >= floor_n;
    end
    if (cmd.chk_b) begin
      spread_r <= (nq_r >= NQ_W'(s2_r)) ? nq_r - NQ_W'(s2_r) : '0;
      rhs_r <= RHS_W'(valid_count - 1'b1) * RHS_W'(s2_r);
    end
    if (cmd.chk_c) begin
      lhs_r <= LHS_W'(spread_r) * LHS_W'(cfg.inv_target_squared);
    end
    if (cmd.chk_d && tested_r) begin
      any_tested <= 1'b1;
      if (CMP_W'(lhs_r) > CMP_W'(rhs_r)) begin
        all_pass <= 1'b0;
      end
    end
    if (cmd.div_init) begin
      dq <= {s_cur, 8'd0};
      rem <= '0;
    end else if (cmd.div_step) begin
      if (r2 >= n_ext) begin
        rem <= r2 - n_ext;
        dq <= {dq[NUM_W-2:0], 1'b1};
      end else begin
        rem <= r2;
        dq <= {dq[NUM_W-2:0], 1'b0};
      end
    end
    if (cmd.div_store) begin
      means[cmd.ch] <= dq[MEAN_W-1:0];
    end
  end

  assign stat.good = good;
  assign stat.valid_count = valid_count;
  assign stat.attempt_count = attempt_count;
  assign stat.hit_streak = hit_streak;
  assign stat.any_tested = any_tested;
  assign stat.all_pass = all_pass;

endmodule

// File: sv/asa_ctrl.sv
// Sequencing state machine of the averager.
`timescale 1ns / 1ps
module asa_ctrl #(
  parameter int MAX_SAMPLES = asa_pkg::DEF_MAX_SAMPLES
) (
  input  logic              clk,
  input  logic              rst,
  input  asa_pkg::cfg_t     cfg,
  input  asa_pkg::dp_stat_t stat,
  input  logic              sample_valid,
  input  logic              out_free,
  output logic              sample_stall,
  output asa_pkg::dp_cmd_t  cmd
);
  import asa_pkg::*;

  localparam int NUM_W = SAMPLE_W + $clog2(MAX_SAMPLES) + 8;
  localparam int BIT_W = $clog2(NUM_W);

  state_t          state, state_next;
  logic [CH_W-1:0] ch, ch_next;
  logic [BIT_W-1:0] bitc, bitc_next;
  logic [1:0]      res_status, res_status_next;

  logic [LIM_W-1:0] limit;
  logic [LIM_W-1:0] need;
  logic [1:0]       confirm;
  logic             at_limit;
  logic             last_ch;
  logic [1:0]       hit_n;
  logic [1:0]       end_status;

  assign limit = (cfg.max_attempts == '0) ? LIM_W'(1) :
                 (LIM_W'(cfg.max_attempts) > LIM_W'(MAX_SAMPLES)) ? LIM_W'(MAX_SAMPLES) :
                 LIM_W'(cfg.max_attempts);
  assign need = (cfg.min_samples < 6'd2) ? LIM_W'(2) : LIM_W'(cfg.min_samples);
  assign confirm = (cfg.confirm_hits == 2'd0) ? 2'd1 : cfg.confirm_hits;
  assign at_limit = LIM_W'(stat.attempt_count) >= limit;
  assign last_ch = ch == CH_W'(CHANNELS - 1);
  assign hit_n = stat.hit_streak + 2'd1;
  assign end_status = (stat.valid_count != '0) ? ST_NOT_CONVERGED : ST_SENSOR_ERROR;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ch <= '0;
      bitc <= '0;
      res_status <= ST_OK;
    end else begin
      state <= state_next;
      ch <= ch_next;
      bitc <= bitc_next;
      res_status <= res_status_next;
    end
  end

  always_comb begin
    state_next = state;
    ch_next = ch;
    bitc_next = bitc;
    res_status_next = res_status;
    case (state)
      S_IDLE: begin
        if (sample_valid) begin
          state_next = S_ACC;
          ch_next = '0;
        end
      end
      S_ACC: begin
        if (last_ch) begin
          state_next = S_DECIDE;
        end else begin
          ch_next = ch + 1'b1;
        end
      end
      S_DECIDE: begin
        ch_next = '0;
        if (!cfg.precise_mode) begin
          if (stat.valid_count != '0) begin
            res_status_next = ST_OK;
            state_next = S_DIV_INIT;
          end else begin
            res_status_next = ST_SENSOR_ERROR;
            state_next = S_LOAD;
          end
        end else if (stat.good && LIM_W'(stat.valid_count) >= need) begin
          state_next = S_CHK_A;
        end else if (at_limit) begin
          res_status_next = end_status;
          state_next = S_LOAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_CHK_A: state_next = S_CHK_B;
      S_CHK_B: state_next = S_CHK_C;
      S_CHK_C: state_next = S_CHK_D;
      S_CHK_D: begin
        if (last_ch) begin
          state_next = S_CHK_END;
        end else begin
          ch_next = ch + 1'b1;
          state_next = S_CHK_A;
        end
      end
      S_CHK_END: begin
        ch_next = '0;
        if (!stat.any_tested || (stat.all_pass && hit_n >= confirm)) begin
          res_status_next = ST_OK;
          state_next = S_DIV_INIT;
        end else if (at_limit) begin
          res_status_next = end_status;
          state_next = S_LOAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DIV_INIT: begin
        bitc_next = '0;
        state_next = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        if (bitc == BIT_W'(NUM_W - 1)) begin
          state_next = S_DIV_STORE;
        end else begin
          bitc_next = bitc + 1'b1;
        end
      end
      S_DIV_STORE: begin
        if (last_ch) begin
          state_next = S_LOAD;
        end else begin
          ch_next = ch + 1'b1;
          state_next = S_DIV_INIT;
        end
      end
      S_LOAD: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.ch = ch;
    cmd.status = res_status;
    sample_stall = 1'b1;
    case (state)
      S_IDLE: begin
        sample_stall = 1'b0;
        cmd.load = sample_valid;
      end
      S_ACC: cmd.acc = 1'b1;
      S_DECIDE: cmd.chk_start = 1'b1;
      S_CHK_A: cmd.chk_a = 1'b1;
      S_CHK_B: cmd.chk_b = 1'b1;
      S_CHK_C: cmd.chk_c = 1'b1;
      S_CHK_D: cmd.chk_d = 1'b1;
      S_CHK_END: begin
        cmd.hit_inc = stat.any_tested && stat.all_pass;
        cmd.hit_clr = stat.any_tested && !stat.all_pass;
      end
      S_DIV_INIT: cmd.div_init = 1'b1;
      S_DIV_STEP: cmd.div_step = 1'b1;
      S_DIV_STORE: cmd.div_store = 1'b1;
      S_LOAD: begin
        cmd.result_load = out_free;
        cmd.clear = out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// File: sv/adaptive_sample_averager_top.sv
// Top level of the adaptive sample averager: registers, result stage, controller, datapath.
`timescale 1ns / 1ps
//
//  channel  direction  handshake                 beat
//  sample   in         sample_valid/sample_stall one read attempt (read_ok, 10 counts)
//  result   out        result_valid/result_stall status and 10 means, 8 fraction bits
//  cfg      in         cfg_valid/cfg_ready       register index and write data
//
//  One attempt at a time. Accumulation takes one channel per cycle.
//  A convergence check runs each channel through states A, B, C and D of the shared multiply chain.
//  A measurement that ends ok runs the restoring divider once per channel;
//  the last attempt of any measurement then loads the result stage once the stage is free.
//  rst is synchronous and clears sums, counters and registers to their defaults.
//  A stalled result holds; a later result waits in the controller until the stage frees.
module adaptive_sample_averager_top #(
  parameter int MAX_SAMPLES = asa_pkg::DEF_MAX_SAMPLES
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  asa_pkg::in_item_t                    sample_data,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output asa_pkg::out_item_t                   result_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [asa_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [asa_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import asa_pkg::*;

  cfg_t      cfg;
  dp_cmd_t   cmd;
  dp_stat_t  stat;
  mean_vec_t means;
  logic      out_free;

  // Registers accept a write in every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.precise_mode <= 1'b1;
      cfg.min_samples <= 6'd8;
      cfg.max_attempts <= 6'd32;
      cfg.inv_target_squared <= 20'd10000;
      cfg.noise_floor <= 16'd50;
      cfg.confirm_hits <= 2'd2;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PRECISE: cfg.precise_mode <= cfg_data[0];
        CFG_MIN_SAMPLES: cfg.min_samples <= cfg_data[5:0];
        CFG_MAX_ATTEMPTS: cfg.max_attempts <= cfg_data[5:0];
        CFG_INV_TARGET: cfg.inv_target_squared <= cfg_data[INV_W-1:0];
        CFG_NOISE_FLOOR: cfg.noise_floor <= cfg_data[FLOOR_W-1:0];
        CFG_CONFIRM: cfg.confirm_hits <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Result stage: free when empty or when its beat leaves this cycle.
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.result_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Zero the means unless the measurement ended ok.
  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      result_data <= build_result(cmd.status, means);
    end
  end

  asa_ctrl #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .stat(stat),
    .sample_valid(sample_valid),
    .out_free(out_free),
    .sample_stall(sample_stall),
    .cmd(cmd)
  );

  asa_datapath #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_datapath (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .item(sample_data),
    .cmd(cmd),
    .stat(stat),
    .means(means)
  );

endmodule

// File: dv/adaptive_sample_averager_checker.sv
// Checker of the adaptive sample averager: watches the channels, predicts and compares results.
`timescale 1ns / 1ps
module adaptive_sample_averager_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           sample_valid,
  input  logic                           sample_stall,
  input  asa_pkg::in_item_t              sample_data,
  input  logic                           result_valid,
  input  logic                           result_stall,
  input  asa_pkg::out_item_t             result_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [asa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [asa_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fails,
  output int                             pending,
  output int                             attempts_seen,
  output int                             results_seen
);
  import asa_pkg::*;

  localparam int SAMPLE_LIMIT = 32;

  cfg_t               regs;
  logic [20:0]        ch_sum [CHANNELS];
  logic [36:0]        ch_sq  [CHANNELS];
  logic [5:0]         n_good;
  logic [5:0]         n_tries;
  logic [1:0]         streak;
  out_item_t          awaited [$];

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fails++;
  endtask

  function automatic logic [15:0] chan_of(in_item_t it, int k);
    return it[159-16*k -: 16];
  endfunction

  task automatic clear_sums();
    for (int k = 0; k < CHANNELS; k++) begin
      ch_sum[k] = '0;
      ch_sq[k] = '0;
    end
    n_good = '0;
    n_tries = '0;
    streak = '0;
  endtask

  // Queue a result with the current sums and clear the measurement.
  task automatic close_measurement(input logic [1:0] st);
    out_item_t r;
    logic [28:0] m;
    r = '0;
    r.status = st;
    for (int k = 0; k < CHANNELS; k++) begin
      m = '0;
      if (st == ST_OK && n_good != 0) m = {ch_sum[k], 8'd0} / 29'(n_good);
      r[239-24*k -: 24] = m[23:0];
    end
    awaited.push_back(r);
    clear_sums();
  endtask

  // 0 nothing tested, 1 every tested channel settled, 2 some channel still noisy.
  function automatic int settle_check();
    logic [127:0] s2, spread, lhs, rhs, nn;
    bit any, all_ok;
    any = 0;
    all_ok = 1;
    nn = 128'(n_good);
    for (int k = 0; k < CHANNELS; k++) begin
      if (128'(ch_sum[k]) < 128'(regs.noise_floor) * nn) continue;
      any = 1;
      s2 = 128'(ch_sum[k]) * 128'(ch_sum[k]);
      spread = nn * 128'(ch_sq[k]);
      spread = (spread >= s2) ? spread - s2 : '0;
      lhs = spread * 128'(regs.inv_target_squared);
      rhs = (nn - 128'd1) * s2;
      if (lhs > rhs) all_ok = 0;
    end
    if (!any) return 0;
    return all_ok ? 1 : 2;
  endfunction

  task automatic take_attempt(input in_item_t it);
    bit good;
    int lim, need, conf, r;
    logic [15:0] v;
    good = it.read_ok;
    n_tries = n_tries + 6'd1;
    if (good && int'(n_good) < SAMPLE_LIMIT) begin
      for (int k = 0; k < CHANNELS; k++) begin
        v = chan_of(it, k);
        ch_sum[k] = ch_sum[k] + 21'(v);
        ch_sq[k] = ch_sq[k] + 37'(v) * 37'(v);
      end
      n_good = n_good + 6'd1;
    end else begin
      good = 0;
    end
    if (!regs.precise_mode) begin
      close_measurement(n_good != 0 ? ST_OK : ST_SENSOR_ERROR);
      return;
    end
    lim = int'(regs.max_attempts);
    if (lim == 0) lim = 1;
    if (lim > SAMPLE_LIMIT) lim = SAMPLE_LIMIT;
    need = (int'(regs.min_samples) < 2) ? 2 : int'(regs.min_samples);
    conf = (regs.confirm_hits == 2'd0) ? 1 : int'(regs.confirm_hits);
    if (good && int'(n_good) >= need) begin
      r = settle_check();
      if (r == 0) begin
        close_measurement(ST_OK);
        return;
      end
      if (r == 1) begin
        streak = streak + 2'd1;
        if (int'(streak) >= conf) begin
          close_measurement(ST_OK);
          return;
        end
      end else begin
        streak = '0;
      end
    end
    if (int'(n_tries) >= lim) begin
      close_measurement(n_good != 0 ? ST_NOT_CONVERGED : ST_SENSOR_ERROR);
    end
  endtask

  initial begin
    fails = 0;
    attempts_seen = 0;
    results_seen = 0;
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      regs = '{precise_mode: 1'b1, min_samples: 6'd8, max_attempts: 6'd32,
               inv_target_squared: 20'd10000, noise_floor: 16'd50, confirm_hits: 2'd2};
      clear_sums();
      awaited.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PRECISE:      regs.precise_mode = cfg_data[0];
          CFG_MIN_SAMPLES:  regs.min_samples = cfg_data[5:0];
          CFG_MAX_ATTEMPTS: regs.max_attempts = cfg_data[5:0];
          CFG_INV_TARGET:   regs.inv_target_squared = cfg_data[19:0];
          CFG_NOISE_FLOOR:  regs.noise_floor = cfg_data[15:0];
          CFG_CONFIRM:      regs.confirm_hits = cfg_data[1:0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        results_seen++;
        if (awaited.size() == 0) begin
          report("unexpected result, status", 64'(result_data.status), 64'd0);
        end else begin
          want = awaited.pop_front();
          if (result_data.status !== want.status)
            report("status", 64'(result_data.status), 64'(want.status));
          for (int k = 0; k < CHANNELS; k++)
            if (result_data[239-24*k -: 24] !== want[239-24*k -: 24])
              report($sformatf("mean_%0d", k), 64'(result_data[239-24*k -: 24]),
                     64'(want[239-24*k -: 24]));
        end
      end
      if (sample_valid && !sample_stall) begin
        attempts_seen++;
        take_attempt(sample_data);
      end
    end
    pending = awaited.size();
  end

endmodule

// File: dv/tb_adaptive_sample_averager_top.sv
// Testbench top of the adaptive sample averager: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_adaptive_sample_averager_top;
  import asa_pkg::*;

  // Worst attempt: load, a check and the divider; allow margin.
  localparam int DRAIN_CYCLES = 500;
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int HOLD_CYCLES  = 3000;
  localparam int PHASES       = 11;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_stall;
  in_item_t sample_data = '0;
  logic result_valid;
  logic result_stall = 1'b1;
  out_item_t result_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fails, pending, attempts_seen, results_seen;
  int cycles = 0;
  bit calm = 0;      // no idling on either side
  bit hold_req = 0;  // ask the receiver for one long hold-off

  // Per-measurement signal shape: base level and spread of each channel.
  int base [CHANNELS];
  int amp  [CHANNELS];

  cfg_t ph_cfg [PHASES];
  int   ph_items [PHASES];
  bit   ph_directed [PHASES];

  always #5 clk = ~clk;

  adaptive_sample_averager_top dut (
    .clk, .rst, .sample_valid, .sample_stall, .sample_data,
    .result_valid, .result_stall, .result_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  adaptive_sample_averager_checker chk (
    .clk, .rst, .sample_valid, .sample_stall, .sample_data,
    .result_valid, .result_stall, .result_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fails, .pending, .attempts_seen, .results_seen
  );

  // Guard against a hung block.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("adaptive_sample_averager_top test failed");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, none when calm.
  initial begin
    int len;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end else if (calm) begin
        result_stall <= 1'b0;
        @(posedge clk);
      end else begin
        len = $urandom_range(1, 11);
        result_stall <= ($urandom_range(0, 2) == 0);
        repeat (len) @(posedge clk);
      end
    end
  end

  // Write every register of one setting; hold valid until each beat lands.
  task automatic write_regs(input cfg_t c);
    logic [CFG_DATA_W-1:0] val [6];
    logic [CFG_IDX_W-1:0] idx [6];
    idx = '{CFG_PRECISE, CFG_MIN_SAMPLES, CFG_MAX_ATTEMPTS,
            CFG_INV_TARGET, CFG_NOISE_FLOOR, CFG_CONFIRM};
    val = '{20'(c.precise_mode), 20'(c.min_samples), 20'(c.max_attempts),
            c.inv_target_squared, 20'(c.noise_floor), 20'(c.confirm_hits)};
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait out every expected result, then the tail of an attempt that ends nothing.
  task automatic drain();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reshape();
    int shift;
    shift = $urandom_range(0, 3);
    for (int k = 0; k < CHANNELS; k++) begin
      case (shift)
        0: base[k] = $urandom_range(0, 200);          // dark, near the floor
        1: base[k] = $urandom_range(0, 65535);
        default: base[k] = $urandom_range(1000, 60000);
      endcase
      amp[k] = base[k] >> $urandom_range(2, 12);
    end
  endtask

  function automatic in_item_t shaped_item();
    in_item_t it;
    int v;
    it = '0;
    it.read_ok = ($urandom_range(0, 9) != 0);
    for (int k = 0; k < CHANNELS; k++) begin
      v = base[k] + $urandom_range(0, 2 * amp[k]) - amp[k];
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      it[159-16*k -: 16] = 16'(v);
    end
    return it;
  endfunction

  function automatic in_item_t directed_item(int i);
    in_item_t it;
    case (i % 6)
      0: it = {1'b1, 160'd0};
      1: it = {1'b1, {160{1'b1}}};
      2: it = {1'b0, {80{2'b10}}};
      3: it = {1'b1, {80{2'b01}}};
      4: it = {1'b1, {80{2'b10}}};
      default: it = {1'($urandom), 32'($urandom), 32'($urandom), 32'($urandom),
                     32'($urandom), 32'($urandom)};
    endcase
    return it;
  endfunction

  // Offer one beat; valid stays high until it is taken.
  task automatic offer(input in_item_t it);
    sample_valid <= 1'b1;
    sample_data <= it;
    do @(posedge clk); while (sample_stall);
  endtask

  initial begin
    in_item_t it;
    int remaining;
    // precise, min, max, inv, floor, confirm
    ph_cfg[0]  = '{1'b0, 6'd8,  6'd32, 20'd10000,   16'd50,    2'd2};
    ph_cfg[1]  = '{1'b1, 6'd0,  6'd0,  20'd0,       16'd0,     2'd0};
    ph_cfg[2]  = '{1'b1, 6'd2,  6'd63, 20'd0,       16'd65535, 2'd0};
    ph_cfg[3]  = '{1'b1, 6'd2,  6'd3,  20'd1000000, 16'd0,     2'd3};
    ph_cfg[4]  = '{1'b1, 6'd8,  6'd32, 20'd10000,   16'd50,    2'd2};
    ph_cfg[5]  = '{1'b1, 6'd4,  6'd20, 20'd100,     16'd1000,  2'd1};
    ph_cfg[6]  = '{1'b0, 6'd63, 6'd1,  20'd500,     16'd10,    2'd1};
    ph_cfg[7]  = '{1'b1, 6'd16, 6'd32, 20'hFFFFF,   16'd0,     2'd3};
    ph_cfg[8]  = '{1'b1, 6'd32, 6'd32, 20'd1,       16'd200,   2'd2};
    ph_cfg[9]  = '{1'b1, 6'd3,  6'd12, 20'd5000,    16'd65535, 2'd1};
    ph_cfg[10] = '{1'b1, 6'd6,  6'd40, 20'd2500,    16'd100,   2'd2};
    ph_items    = '{6, 4, 6, 6, 120, 120, 80, 120, 120, 60, 80};
    ph_directed = '{1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < PHASES; p++) begin
      write_regs(ph_cfg[p]);
      calm = (p == PHASES - 1);
      // Fast mode yields a result per beat: fill the block behind a long hold-off.
      if (p == 6) hold_req = 1;
      remaining = 0;
      for (int i = 0; i < ph_items[p]; i++) begin
        if (ph_directed[p]) begin
          it = directed_item(i);
        end else begin
          if (remaining == 0) begin
            reshape();
            remaining = $urandom_range(3, 40);
          end
          remaining--;
          case ($urandom_range(0, 9))
            0: it = directed_item(5);
            default: it = shaped_item();
          endcase
        end
        if (!calm && $urandom_range(0, 3) == 0) begin
          sample_valid <= 1'b0;
          repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        offer(it);
        // Pause the sender once until every result is home.
        if (p == 5 && i == 60) begin
          sample_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
      end
      drain();
    end

    $display("covered %0d read attempts and %0d results over %0d register settings",
             attempts_seen, results_seen, PHASES);
    $display("settings span fast and precise modes and the register extremes");
    if (fails == 0) begin
      $display("adaptive_sample_averager_top test passed");
    end else begin
      $display("adaptive_sample_averager_top test failed");
    end
    $finish;
  end

endmodule
